// ----- rtl/core/bitmap_inode_block_allocator_assert.svh -----
// assertion macros for the bitmap inode and block allocator
`ifndef BITMAP_INODE_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_INODE_BLOCK_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define BIBA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define BIBA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/biba_pkg.sv -----
// shared types and constants for the bitmap inode and block allocator
package biba_pkg;

    localparam int DEF_INODE_TOTAL = 64;
    localparam int DEF_MAP_BLOCKS  = 4096;

    localparam int WORD_BITS  = 64;
    localparam int WORD_IDX_W = 6;

    localparam int ROOT_INODE       = 1;
    localparam int FIRST_FREE_INODE = 2;
    localparam int FIRST_DATA_BLOCK = 8;
    localparam int RESERVED_LAST    = 7;

    // reset contents of block map row 0: blocks 0 through the last reserved one
    localparam logic [WORD_BITS-1:0] ROW0_RESET =
        (WORD_BITS'(1) << (RESERVED_LAST + 1)) - WORD_BITS'(1);

    localparam logic [2:0] KIND_ALLOC_PAIR  = 3'd0;
    localparam logic [2:0] KIND_ALLOC_BLOCK = 3'd1;
    localparam logic [2:0] KIND_FREE_INODE  = 3'd2;
    localparam logic [2:0] KIND_FREE_BLOCK  = 3'd3;
    localparam logic [2:0] KIND_FORMAT      = 3'd4;
    localparam logic [2:0] KIND_TEST_INODE  = 3'd5;
    localparam logic [2:0] KIND_TEST_BLOCK  = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ISCAN,
        ST_BSCAN,
        ST_COMMIT,
        ST_MRD,
        ST_MOD
    } state_t;

    typedef struct packed {
        logic                  found;
        logic [WORD_IDX_W-1:0] pos;
    } ffz_res_t;

endpackage

// ----- rtl/core/bitmap_inode_block_allocator.sv -----
// top level of the bitmap inode and block allocator
//
// usage
//   one request word enters on start/kind/index when start is high and busy is low;
//   busy stays high until the result is done, one request at a time
//   every request gives exactly one result word: done pulses for one cycle with
//   status, inode_number, block_number and bit_was_set; the receiver cannot stall
//   the user writes device_blocks by cfg_we only while the block is idle; the block does not enforce it
// request flow, from accept to done
//   free inode, test inode, format, unused kind: done from the exec state
//   free block, test block: exec, then one block map ram read (mrd), then mod
//   alloc block: exec, then the block scan reads one 64-bit block map row per cycle through the
//   shared first-free unit, then commit
//   alloc pair: scans the inode map first, one 64-bit word per cycle, then as alloc block
// reset
//   inode map comes back with inode 0 and the root set, device_blocks with 4096;
//   block map rows carry valid bits that reset and format clear together,
//   and a row not yet written reads as its reset pattern (blocks 0..7 used)
module bitmap_inode_block_allocator
    import biba_pkg::*;
    #(
        parameter int INODE_TOTAL = DEF_INODE_TOTAL,
        parameter int MAP_BLOCKS  = DEF_MAP_BLOCKS
    )
    (
        input  logic        clk,
        input  logic        rst_n,
        input  logic        start,
        input  logic [2:0]  kind,
        input  logic [11:0] index,
        output logic        busy,
        input  logic        cfg_we,
        input  logic [12:0] device_blocks,
        output logic        done,
        output logic        status,
        output logic [6:0]  inode_number,
        output logic [11:0] block_number,
        output logic        bit_was_set
    );

    `include "bitmap_inode_block_allocator_assert.svh"

    // geometry
    localparam int IM    = INODE_TOTAL + 1;
    localparam int IIW   = $clog2(IM);
    localparam int NIW   = (IM + WORD_BITS - 1) / WORD_BITS;
    localparam int IPW   = (NIW > 1) ? $clog2(NIW) : 1;
    localparam int NW    = (MAP_BLOCKS + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = (NW > 1) ? $clog2(NW) : 1;
    localparam int BND_W = ($clog2(MAP_BLOCKS + 1) > 13) ? $clog2(MAP_BLOCKS + 1) : 13;
    localparam int PW    = BND_W - WORD_IDX_W;

    localparam logic [IM-1:0] INODE_INIT = (IM'(1) << ROOT_INODE) | IM'(1);

    // control and map state
    state_t                    state_reg, state_next;
    logic [2:0]                kind_reg, kind_next;
    logic [11:0]               idx_reg, idx_next;
    logic [12:0]               dev_reg;
    logic [IM-1:0]             inode_map_reg, inode_map_next;
    logic [NW-1:0]             row_vld_reg, row_vld_next;
    logic [IPW-1:0]            iw_reg, iw_next;
    logic [IPW+WORD_IDX_W-1:0] ifound_reg, ifound_next;

    // block map read pipeline and found block
    logic [PW-1:0]             rd_ptr_reg, rd_ptr_next;
    logic [PW-1:0]             q_ptr_reg;
    logic                      q_vld_reg;
    logic                      q_rv_reg;
    logic [WORD_BITS-1:0]      fw_reg, fw_next;
    logic [WORD_IDX_W-1:0]     fpos_reg, fpos_next;
    logic [PW-1:0]             fptr_reg, fptr_next;

    // result word
    logic                      done_reg, done_next;
    logic                      status_reg, status_next;
    logic [6:0]                inode_number_reg, inode_number_next;
    logic [11:0]               block_number_reg, block_number_next;
    logic                      bit_reg, bit_next;

    // datapath wires
    logic [BND_W-1:0]          bnd;
    logic [BND_W-1:0]          bnd_m1;
    logic [PW-1:0]             last_ptr;
    logic [WORD_IDX_W:0]       hi_last;
    logic                      blk_search_ok;
    logic                      free_blk_ok;
    logic                      inode_in_range;
    logic                      test_blk_ok;
    logic [NIW*WORD_BITS-1:0]  ipad;
    logic [WORD_BITS-1:0]      ichunk;
    logic [WORD_BITS-1:0]      eff_word;
    logic [WORD_BITS-1:0]      unit_word;
    logic [WORD_IDX_W-1:0]     unit_lo;
    logic [WORD_IDX_W:0]       unit_hi;
    ffz_res_t                  unit_res;
    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [WORD_BITS-1:0]      ram_wdata;
    logic [WORD_BITS-1:0]      ram_rdata;
    logic [PW+WORD_IDX_W-1:0]  commit_blk;
    logic                      fin;
    logic                      fin_status;
    logic                      fin_bit;
    logic [6:0]                fin_inode;
    logic [11:0]               fin_block;

    // block search bound is the smaller of the device size and the map size
    assign bnd = (BND_W'(dev_reg) < BND_W'(MAP_BLOCKS)) ? BND_W'(dev_reg) : BND_W'(MAP_BLOCKS);
    assign bnd_m1        = bnd - BND_W'(1);
    assign last_ptr      = bnd_m1[BND_W-1:WORD_IDX_W];
    assign hi_last       = {bnd[WORD_IDX_W-1:0] == '0, bnd[WORD_IDX_W-1:0]};
    assign blk_search_ok = bnd > BND_W'(FIRST_DATA_BLOCK);
    assign free_blk_ok   = (idx_reg != '0) && (BND_W'(idx_reg) < bnd);
    assign inode_in_range = 32'(idx_reg) <= INODE_TOTAL;
    assign test_blk_ok   = 32'(idx_reg) < MAP_BLOCKS;

    // full number of the block found by the scan
    assign commit_blk = {fptr_reg, fpos_reg};

    // inode map padded with used bits up to a whole number of words
    always_comb
    begin
        ipad         = '1;
        ipad[IM-1:0] = inode_map_reg;
    end
    assign ichunk = ipad[iw_reg*WORD_BITS +: WORD_BITS];

    // a row never written since reset or format reads as its reset pattern
    assign eff_word = q_rv_reg ? ram_rdata : ((q_ptr_reg == '0) ? ROW0_RESET : '0);

    // shared first-free unit: inode words during the inode scan, else block rows
    always_comb
    begin
        if (state_reg == ST_ISCAN)
        begin
            unit_word = ichunk;
            unit_lo   = (iw_reg == '0) ? WORD_IDX_W'(FIRST_FREE_INODE) : '0;
            unit_hi   = (WORD_IDX_W+1)'(WORD_BITS);
        end
        else
        begin
            unit_word = eff_word;
            unit_lo   = (q_ptr_reg == '0) ? WORD_IDX_W'(FIRST_DATA_BLOCK) : '0;
            unit_hi   = (q_ptr_reg == last_ptr) ? hi_last : (WORD_IDX_W+1)'(WORD_BITS);
        end
    end

    biba_ffz u_ffz
    (
        .word (unit_word),
        .lo   (unit_lo),
        .hi   (unit_hi),
        .res  (unit_res)
    );

    biba_ram
    #(
        .WIDTH (WORD_BITS),
        .DEPTH (NW)
    )
    u_block_map
    (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_ptr_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                case (kind_reg)
                    KIND_ALLOC_PAIR:  state_next = ST_ISCAN;
                    KIND_ALLOC_BLOCK: state_next = blk_search_ok ? ST_BSCAN : ST_IDLE;
                    KIND_FREE_BLOCK:  state_next = free_blk_ok ? ST_MRD : ST_IDLE;
                    KIND_TEST_BLOCK:  state_next = test_blk_ok ? ST_MRD : ST_IDLE;
                    default:          state_next = ST_IDLE;
                endcase
            end
            ST_ISCAN:
            begin
                if (unit_res.found)
                begin
                    state_next = blk_search_ok ? ST_BSCAN : ST_IDLE;
                end
                else if (32'(iw_reg) == NIW - 1)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_BSCAN:
            begin
                if (q_vld_reg && unit_res.found)
                begin
                    state_next = ST_COMMIT;
                end
                else if (q_vld_reg && (q_ptr_reg == last_ptr))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_COMMIT: state_next = ST_IDLE;
            ST_MRD:    state_next = ST_MOD;
            ST_MOD:    state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        kind_next      = kind_reg;
        idx_next       = idx_reg;
        inode_map_next = inode_map_reg;
        row_vld_next   = row_vld_reg;
        iw_next        = iw_reg;
        ifound_next    = ifound_reg;
        rd_ptr_next    = rd_ptr_reg;
        fw_next        = fw_reg;
        fpos_next      = fpos_reg;
        fptr_next      = fptr_reg;
        ram_we         = 1'b0;
        ram_waddr      = fptr_reg[AW-1:0];
        ram_wdata      = fw_reg | (WORD_BITS'(1) << fpos_reg);
        fin            = 1'b0;
        fin_status     = 1'b0;
        fin_bit        = 1'b0;
        fin_inode      = '0;
        fin_block      = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    kind_next = kind;
                    idx_next  = index;
                end
            end
            ST_EXEC:
            begin
                rd_ptr_next = '0;
                iw_next     = '0;
                case (kind_reg)
                    KIND_ALLOC_PAIR:
                    begin
                    end
                    KIND_ALLOC_BLOCK:
                    begin
                        fin        = !blk_search_ok;
                        fin_status = !blk_search_ok;
                    end
                    KIND_FREE_INODE:
                    begin
                        if (inode_in_range)
                        begin
                            inode_map_next[idx_reg[IIW-1:0]] = 1'b0;
                        end
                        fin = 1'b1;
                    end
                    KIND_FREE_BLOCK:
                    begin
                        rd_ptr_next = PW'(idx_reg[11:WORD_IDX_W]);
                        fin         = !free_blk_ok;
                    end
                    KIND_FORMAT:
                    begin
                        inode_map_next = INODE_INIT;
                        row_vld_next   = '0;
                        fin            = 1'b1;
                    end
                    KIND_TEST_INODE:
                    begin
                        fin     = 1'b1;
                        fin_bit = inode_in_range && inode_map_reg[idx_reg[IIW-1:0]];
                    end
                    KIND_TEST_BLOCK:
                    begin
                        rd_ptr_next = PW'(idx_reg[11:WORD_IDX_W]);
                        fin         = !test_blk_ok;
                    end
                    default:
                    begin
                        fin = 1'b1;
                    end
                endcase
            end
            ST_ISCAN:
            begin
                if (unit_res.found)
                begin
                    ifound_next = {iw_reg, unit_res.pos};
                    fin         = !blk_search_ok;
                    fin_status  = !blk_search_ok;
                end
                else if (32'(iw_reg) == NIW - 1)
                begin
                    fin        = 1'b1;
                    fin_status = 1'b1;
                end
                else
                begin
                    iw_next = iw_reg + IPW'(1);
                end
            end
            ST_BSCAN:
            begin
                // one row read per cycle, checked the cycle after
                rd_ptr_next = rd_ptr_reg + PW'(1);
                if (q_vld_reg && unit_res.found)
                begin
                    fw_next   = eff_word;
                    fpos_next = unit_res.pos;
                    fptr_next = q_ptr_reg;
                end
                else if (q_vld_reg && (q_ptr_reg == last_ptr))
                begin
                    fin        = 1'b1;
                    fin_status = 1'b1;
                end
            end
            ST_COMMIT:
            begin
                ram_we                        = 1'b1;
                row_vld_next[fptr_reg[AW-1:0]] = 1'b1;
                if (kind_reg == KIND_ALLOC_PAIR)
                begin
                    inode_map_next[ifound_reg[IIW-1:0]] = 1'b1;
                    fin_inode = ifound_reg[6:0];
                end
                fin       = 1'b1;
                fin_block = commit_blk[11:0];
            end
            ST_MRD:
            begin
            end
            ST_MOD:
            begin
                fin = 1'b1;
                if (kind_reg == KIND_FREE_BLOCK)
                begin
                    ram_we                          = 1'b1;
                    ram_waddr                       = q_ptr_reg[AW-1:0];
                    ram_wdata = eff_word & ~(WORD_BITS'(1) << idx_reg[WORD_IDX_W-1:0]);
                    row_vld_next[q_ptr_reg[AW-1:0]] = 1'b1;
                end
                else
                begin
                    fin_bit = eff_word[idx_reg[WORD_IDX_W-1:0]];
                end
            end
            default:
            begin
            end
        endcase

        done_next         = fin;
        status_next       = fin ? fin_status : status_reg;
        inode_number_next = fin ? fin_inode : inode_number_reg;
        block_number_next = fin ? fin_block : block_number_reg;
        bit_next          = fin ? fin_bit : bit_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            dev_reg       <= 13'd4096;
            inode_map_reg <= INODE_INIT;
            row_vld_reg   <= '0;
            q_vld_reg     <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            inode_map_reg <= inode_map_next;
            row_vld_reg   <= row_vld_next;
            q_vld_reg     <= (state_reg == ST_BSCAN);
            done_reg      <= done_next;
            if (cfg_we)
            begin
                dev_reg <= device_blocks;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        kind_reg         <= kind_next;
        idx_reg          <= idx_next;
        iw_reg           <= iw_next;
        ifound_reg       <= ifound_next;
        rd_ptr_reg       <= rd_ptr_next;
        q_ptr_reg        <= rd_ptr_reg;
        q_rv_reg         <= row_vld_reg[rd_ptr_reg[AW-1:0]];
        fw_reg           <= fw_next;
        fpos_reg         <= fpos_next;
        fptr_reg         <= fptr_next;
        status_reg       <= status_next;
        inode_number_reg <= inode_number_next;
        block_number_reg <= block_number_next;
        bit_reg          <= bit_next;
    end

    assign busy         = (state_reg != ST_IDLE);
    assign done         = done_reg;
    assign status       = status_reg;
    assign inode_number = inode_number_reg;
    assign block_number = block_number_reg;
    assign bit_was_set  = bit_reg;

    // checks
    `BIBA_ASSERT_NXT(a_accept_busy, clk, rst_n, start && !busy, busy, "accepted word did not raise busy")
    `BIBA_ASSERT_IMP(a_done_from_work, clk, rst_n, done, $past(state_reg) != ST_IDLE, "done without work")
    `BIBA_ASSERT_IMP(a_nospace_zero, clk, rst_n, done && status, (inode_number == '0) && (block_number == '0), "no space word carries numbers")
    `BIBA_ASSERT_IMP(a_commit_after_scan, clk, rst_n, state_reg == ST_COMMIT, $past(state_reg) == ST_BSCAN, "commit not preceded by block scan")

endmodule

// ----- rtl/core/biba_ram.sv -----
// generic single-port-write ram with registered read
module biba_ram
    #(
        parameter int WIDTH = 64,
        parameter int DEPTH = 64,
        localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic             clk,
        input  logic             we,
        input  logic [AW-1:0]    waddr,
        input  logic [WIDTH-1:0] wdata,
        input  logic [AW-1:0]    raddr,
        output logic [WIDTH-1:0] rdata
    );

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/core/biba_ffz.sv -----
// first free bit finder over one map word, bounded by a low and a high bit
module biba_ffz
    import biba_pkg::*;
    (
        input  logic [WORD_BITS-1:0]  word,
        input  logic [WORD_IDX_W-1:0] lo,
        input  logic [WORD_IDX_W:0]   hi,
        output ffz_res_t              res
    );

    logic [WORD_BITS-1:0]  mask;
    logic [WORD_BITS-1:0]  cand;
    logic [WORD_BITS-1:0]  lowest;
    logic [WORD_IDX_W-1:0] pos;

    always_comb
    begin
        for (int j = 0; j < WORD_BITS; j++)
        begin
            mask[j] = ((WORD_IDX_W+1)'(j) >= {1'b0, lo}) && ((WORD_IDX_W+1)'(j) < hi);
        end
    end

    // free and eligible bits, then isolate the lowest one
    assign cand   = ~word & mask;
    assign lowest = cand & (~cand + WORD_BITS'(1));

    always_comb
    begin
        pos = '0;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            if (lowest[j])
            begin
                pos = pos | WORD_IDX_W'(j);
            end
        end
    end

    assign res.found = |cand;
    assign res.pos   = pos;

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the bitmap inode and block allocator
`timescale 1ns / 100ps

module tb_top
    import biba_pkg::*;
    ;

    // kind 7 has no name in the package: the block must treat it as a no-op
    localparam logic [2:0] KIND_NOP = 3'd7;

    // watchdog: cycles with neither a request nor a reply word accepted
    localparam int STALL_LIMIT = 5000;
    // slowest request is a pair alloc at full size
    localparam int TAIL_CYCLES = 100;

    // one reply word as it leaves the block
    typedef struct packed {
        logic        status;
        logic [6:0]  inode_number;
        logic [11:0] block_number;
        logic        bit_was_set;
    } alloc_reply_t;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic [2:0]  kind;
    logic [11:0] index;
    logic        busy;
    logic        cfg_we;
    logic [12:0] device_blocks;
    logic        done;
    logic        status;
    logic [6:0]  inode_number;
    logic [11:0] block_number;
    logic        bit_was_set;

    // shadow copy of the allocator state, advanced at each accepted request
    bit           inode_used [0:DEF_INODE_TOTAL];
    bit           block_used [0:DEF_MAP_BLOCKS-1];
    logic [12:0]  device_size;
    int           block_top;       // highest block handed out since the last format

    alloc_reply_t owed_replies [$];  // predicted reply words, oldest first
    int           mismatches;
    int           stall_cycles;

    bitmap_inode_block_allocator u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .kind         (kind),
        .index        (index),
        .busy         (busy),
        .cfg_we       (cfg_we),
        .device_blocks(device_blocks),
        .done         (done),
        .status       (status),
        .inode_number (inode_number),
        .block_number (block_number),
        .bit_was_set  (bit_was_set)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // fresh layout: inode 0 and the root, blocks 0 through the last reserved one
    function automatic void lay_out_fresh();
        foreach (inode_used[i]) inode_used[i] = 1'b0;
        foreach (block_used[i]) block_used[i] = 1'b0;
        inode_used[0]          = 1'b1;
        inode_used[ROOT_INODE] = 1'b1;
        for (int b = 0; b <= RESERVED_LAST; b++)
            block_used[b] = 1'b1;
        block_top = FIRST_DATA_BLOCK;
    endfunction

    // search bound is the smaller of the device size and the map size
    function automatic int block_limit();
        return (int'(device_size) < DEF_MAP_BLOCKS) ? int'(device_size) : DEF_MAP_BLOCKS;
    endfunction

    // lowest free data block below the bound, 0 when the map is full
    function automatic int first_free_block();
        int lim;
        lim = block_limit();
        for (int b = FIRST_DATA_BLOCK; b < lim; b++)
            if (!block_used[b])
                return b;
        return 0;
    endfunction

    // applies one request to the shadow maps and returns the reply word it owes
    function automatic alloc_reply_t serve_request(logic [2:0] k, logic [11:0] idx);
        alloc_reply_t r;
        int           fi;
        int           fb;
        r  = '0;
        fi = 0;
        fb = 0;
        case (k)
            KIND_ALLOC_PAIR:
            begin
                for (int i = FIRST_FREE_INODE; i <= DEF_INODE_TOTAL; i++)
                    if (fi == 0 && !inode_used[i])
                        fi = i;
                // the block search only counts when an inode was found
                if (fi != 0)
                    fb = first_free_block();
                if (fi == 0 || fb == 0)
                    r.status = 1'b1;
                else
                begin
                    inode_used[fi] = 1'b1;
                    block_used[fb] = 1'b1;
                    r.inode_number = 7'(fi);
                    r.block_number = 12'(fb);
                end
            end
            KIND_ALLOC_BLOCK:
            begin
                fb = first_free_block();
                if (fb == 0)
                    r.status = 1'b1;
                else
                begin
                    block_used[fb] = 1'b1;
                    r.block_number = 12'(fb);
                end
            end
            KIND_FREE_INODE:
                // inode 0 and the root clear like any other; above the map is ignored
                if (idx <= DEF_INODE_TOTAL)
                    inode_used[idx] = 1'b0;
            KIND_FREE_BLOCK:
                if (idx != 0 && int'(idx) < block_limit())
                    block_used[idx] = 1'b0;
            KIND_FORMAT:
                lay_out_fresh();
            KIND_TEST_INODE:
                if (idx <= DEF_INODE_TOTAL)
                    r.bit_was_set = inode_used[idx];
            KIND_TEST_BLOCK:
                if (idx < DEF_MAP_BLOCKS)
                    r.bit_was_set = block_used[idx];
            default:
                r = '0;
        endcase
        if (fb > block_top)
            block_top = fb;
        return r;
    endfunction

    // drive one request word and wait for the edge that takes it
    task automatic send_request(input logic [2:0] k, input logic [11:0] idx);
        @(negedge clk);
        start <= 1'b1;
        kind  <= k;
        index <= idx;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        owed_replies.push_back(serve_request(k, idx));
    endtask

    // hold start low between requests, for as long as n says
    task automatic idle_for(input int n);
        @(negedge clk);
        start <= 1'b0;
        repeat (n - 1) @(negedge clk);
    endtask

    // stop sending and wait for every owed reply and for busy to drop
    task automatic settle_idle();
        @(negedge clk);
        start <= 1'b0;
        while (owed_replies.size() != 0 || busy !== 1'b0)
            @(posedge clk);
    endtask

    // register write, only while the block is idle
    task automatic set_device_blocks(input int unsigned v);
        settle_idle();
        @(negedge clk);
        cfg_we        <= 1'b1;
        device_blocks <= v[12:0];
        @(negedge clk);
        cfg_we        <= 1'b0;
        device_size   = v[12:0];
    endtask

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
        end
    endtask

    // every done cycle carries one reply word; compare it with the oldest prediction
    always @(posedge clk)
    begin
        alloc_reply_t want;
        if (rst_n && done === 1'b1)
        begin
            if (owed_replies.size() == 0)
            begin
                mismatches++;
                $display("%0t: reply word with nothing owed, expected none actual %0d/%0d/%0d/%0d",
                         $time, status, inode_number, block_number, bit_was_set);
            end
            else
            begin
                want = owed_replies.pop_front();
                check_field("status",       want.status,       status);
                check_field("inode_number", want.inode_number, inode_number);
                check_field("block_number", want.block_number, block_number);
                check_field("bit_was_set",  want.bit_was_set,  bit_was_set);
            end
        end
    end

    // watchdog: anything accepted on either side restarts the count
    always @(posedge clk)
    begin
        if ((start === 1'b1 && busy === 1'b0) || done === 1'b1)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("%0t: no word accepted for %0d cycles", $time, STALL_LIMIT);
            $display("** bitmap_inode_block_allocator: FAILED **");
            $finish;
        end
    end

    // index aimed at the interesting part of the map for each kind
    function automatic logic [11:0] pick_index(logic [2:0] k);
        int r;
        int hi;
        r  = $urandom_range(0, 99);
        hi = (block_top + 4 > 4095) ? 4095 : block_top + 4;
        case (k)
            KIND_FREE_INODE, KIND_TEST_INODE:
                // mostly inside the inode map, now and then far beyond it
                return (r < 85) ? 12'($urandom_range(0, DEF_INODE_TOTAL + 2))
                                : 12'($urandom_range(0, 4095));
            KIND_FREE_BLOCK, KIND_TEST_BLOCK:
                if (r < 65)
                    return 12'($urandom_range(0, hi));      // among allocated blocks
                else if (r < 85)
                    return 12'(block_limit() - 2 + $urandom_range(0, 3));  // around the bound
                else
                    return 12'($urandom_range(0, 4095));
            default:
                return 12'($urandom_range(0, 4095));
        endcase
    endfunction

    // field extremes, every kind at least once, out-of-range frees and tests, root free, no-op
    task automatic test_directed_edges();
        send_request(KIND_TEST_INODE,  12'd0);
        send_request(KIND_TEST_INODE,  12'(ROOT_INODE));
        send_request(KIND_TEST_INODE,  12'(DEF_INODE_TOTAL + 1));
        send_request(KIND_TEST_BLOCK,  12'(RESERVED_LAST));
        send_request(KIND_TEST_BLOCK,  12'd4095);
        send_request(KIND_ALLOC_PAIR,  12'd0);
        send_request(KIND_ALLOC_BLOCK, 12'd4095);
        send_request(KIND_FREE_INODE,  12'd4095);
        send_request(KIND_FREE_BLOCK,  12'd0);
        send_request(KIND_FREE_BLOCK,  12'(FIRST_DATA_BLOCK + 1));
        send_request(KIND_ALLOC_BLOCK, 12'd0);
        send_request(KIND_FREE_INODE,  12'(ROOT_INODE));
        send_request(KIND_TEST_INODE,  12'(ROOT_INODE));
        send_request(KIND_NOP,         12'd4095);
        send_request(KIND_FORMAT,      12'd0);
    endtask

    // smallest device: block search runs dry, bound edge frees, format at small size
    task automatic test_small_device();
        set_device_blocks(16);
        repeat (9) send_request(KIND_ALLOC_BLOCK, 12'd0);
        send_request(KIND_ALLOC_PAIR, 12'd0);
        send_request(KIND_FREE_BLOCK, 12'd16);
        send_request(KIND_FREE_BLOCK, 12'd15);
        send_request(KIND_ALLOC_PAIR, 12'd0);
        send_request(KIND_FORMAT,     12'd0);
    endtask

    // random request mix; alloc_pct steers how hard the maps fill up
    task automatic run_mix(input int n, input int alloc_pct, input int format_pct,
                           input bit with_gaps);
        logic [2:0] k;
        int         r;
        bit         gaps_now;
        gaps_now = 1'b0;
        for (int i = 0; i < n; i++)
        begin
            // gaps come and go in stretches of 16 words
            if (i % 16 == 0)
                gaps_now = with_gaps && ($urandom_range(0, 2) != 0);
            r = $urandom_range(0, 99);
            if (r < alloc_pct)
                k = ($urandom_range(0, 1) != 0) ? KIND_ALLOC_BLOCK : KIND_ALLOC_PAIR;
            else if (r < alloc_pct + format_pct)
                k = KIND_FORMAT;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 28)      k = KIND_FREE_INODE;
                else if (r < 58) k = KIND_FREE_BLOCK;
                else if (r < 76) k = KIND_TEST_INODE;
                else if (r < 97) k = KIND_TEST_BLOCK;
                else             k = KIND_NOP;
            end
            if (gaps_now && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 8));
            send_request(k, pick_index(k));
        end
    endtask

    // phases of random traffic over a spread of device sizes, 0 means a random size
    task automatic test_random_traffic();
        int sizes [10];
        int fills [10];
        int sz;
        sizes = '{4096, 16, 17, 0, 64, 4095, 0, 1000, 20, 4096};
        fills = '{95, 60, 70, 50, 40, 85, 30, 50, 60, 45};
        for (int p = 0; p < 10; p++)
        begin
            sz = (sizes[p] == 0) ? $urandom_range(16, 4096) : sizes[p];
            set_device_blocks(sz);
            // first phase runs without formats so the inode map fills up
            run_mix(135, fills[p], (p == 0) ? 0 : 2, p != 9);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        start         = 1'b0;
        kind          = KIND_NOP;
        index         = '0;
        cfg_we        = 1'b0;
        device_blocks = 13'd4096;
        mismatches    = 0;
        stall_cycles  = 0;
        device_size   = 13'd4096;
        lay_out_fresh();
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        test_directed_edges();
        test_small_device();
        test_random_traffic();

        // drain, then leave room for a late stray reply word
        settle_idle();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && owed_replies.size() == 0)
            $display("** bitmap_inode_block_allocator: PASSED **");
        else
            $display("** bitmap_inode_block_allocator: FAILED **");
        $finish;
    end

endmodule

// ----- bitmap_inode_block_allocator.f -----
+incdir+rtl/core
rtl/core/biba_pkg.sv
rtl/core/biba_ram.sv
rtl/core/biba_ffz.sv
rtl/core/bitmap_inode_block_allocator.sv
dv/tb_top.sv
